// File: hw/rtl/mer_pkg.sv
// shared constants, codes and item types of the midpoint ellipse rasterizer
package mer_pkg;

   localparam int COORD_BITS     = 12;
   localparam int RADIUS_BITS    = 11;
   localparam int COLOR_BITS     = 32;
   localparam int CENTER_BITS    = 16;
   localparam int CFG_BITS       = 13;
   localparam int CSR_INDEX_BITS = 2;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TARGET_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TARGET_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FILL_MODE     = 2'd2;

   localparam logic [CFG_BITS-1:0] TARGET_WIDTH_RESET  = 13'd640;
   localparam logic [CFG_BITS-1:0] TARGET_HEIGHT_RESET = 13'd480;
   localparam logic                FILL_MODE_RESET     = 1'b0;

   // request codes on the input channel
   localparam logic REQ_START = 1'b0;
   localparam logic REQ_STEP  = 1'b1;

   // command codes held in the queue
   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_ADVANCE = 1'b1;

   typedef struct packed {
      logic                          req_type;
      logic signed [CENTER_BITS-1:0] center_x;
      logic signed [CENTER_BITS-1:0] center_y;
      logic [RADIUS_BITS-1:0]        radius_x;
      logic [RADIUS_BITS-1:0]        radius_y;
      logic [COLOR_BITS-1:0]         color;
   } req_item_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] pixel_x;
      logic [COORD_BITS-1:0] span_end_x;
      logic [COORD_BITS-1:0] pixel_y;
      logic [COLOR_BITS-1:0] pixel_color;
      logic                  visible;
      logic                  last;
      logic                  done_res;
   } rsp_item_type;

   typedef struct packed {
      logic                          op;
      logic signed [CENTER_BITS-1:0] center_x;
      logic signed [CENTER_BITS-1:0] center_y;
      logic [RADIUS_BITS-1:0]        radius_x;
      logic [RADIUS_BITS-1:0]        radius_y;
      logic [COLOR_BITS-1:0]         color;
   } cmd_item_type;

   typedef struct packed {
      logic         valid;
      cmd_item_type cmd;
   } queue_head_type;

endpackage

// File: hw/rtl/mer_front.sv
// front end: takes request items, decodes them into commands and queues them
module mer_front #(
   parameter int QUEUE_DEPTH = mer_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  mer_pkg::req_item_type   req_data,
   output mer_pkg::queue_head_type head,
   input  logic                    pop
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   mer_pkg::cmd_item_type queue_ff [QUEUE_DEPTH];
   mer_pkg::cmd_item_type cmd_c;

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             full;

   always_comb begin
      cmd_c.center_x = req_data.center_x;
      cmd_c.center_y = req_data.center_y;
      cmd_c.radius_x = req_data.radius_x;
      cmd_c.radius_y = req_data.radius_y;
      cmd_c.color    = req_data.color;
      unique case (req_data.req_type)
         mer_pkg::REQ_START: cmd_c.op = mer_pkg::CMD_LOAD;
         mer_pkg::REQ_STEP:  cmd_c.op = mer_pkg::CMD_ADVANCE;
         default:            cmd_c.op = mer_pkg::CMD_ADVANCE;
      endcase
   end

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign req_stall = full;
   assign push      = req_valid && !full;

   assign head.valid = (count_ff != '0);
   assign head.cmd   = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd_c;
      end
   end

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("queue popped while empty");

endmodule

// File: hw/rtl/mer_back.sv
// back end: ellipse walk engine, configuration registers and result register
module mer_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_en,
   input  logic [mer_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [mer_pkg::CFG_BITS-1:0]          csr_wdata,
   input  mer_pkg::queue_head_type               head,
   output logic                                  pop,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output mer_pkg::rsp_item_type                 rsp_data
);

   localparam int CB     = mer_pkg::COORD_BITS;
   localparam int RB     = mer_pkg::RADIUS_BITS;
   localparam int CW     = mer_pkg::CENTER_BITS;
   localparam int OX_W   = CB + 1;
   localparam int OY_W   = RB + 2;
   localparam int OFF_W  = (OX_W > OY_W ? OX_W : OY_W) + 1;
   localparam int POS_W  = (CW > OFF_W ? CW : OFF_W) + 1;
   localparam int SQ_W   = 2 * RB;
   localparam int PROD_W = 3 * RB;
   localparam int DEC_W  = 3 * RB + 8;
   localparam int SZ_W   = CB + 1;
   localparam int EXT_W  = (mer_pkg::CFG_BITS > SZ_W) ? mer_pkg::CFG_BITS : SZ_W;

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_PRIME_SQ  = 3'd1;
   localparam logic [2:0] ST_PRIME_MUL = 3'd2;
   localparam logic [2:0] ST_PRIME_SET = 3'd3;
   localparam logic [2:0] ST_TEST      = 3'd4;
   localparam logic [2:0] ST_UPDATE    = 3'd5;
   localparam logic [2:0] ST_EMIT      = 3'd6;

   localparam logic [1:0] REGION_ONE  = 2'd0;
   localparam logic [1:0] REGION_TWO  = 2'd1;
   localparam logic [1:0] REGION_DONE = 2'd2;

   localparam logic [1:0] SLOT_SPAN_LAST  = 2'd1;
   localparam logic [1:0] SLOT_POINT_LAST = 2'd3;

   function automatic logic [SZ_W-1:0] eff_size(input logic [mer_pkg::CFG_BITS-1:0] v);
      logic [EXT_W-1:0] ve;
      logic [EXT_W-1:0] lim;
      ve       = EXT_W'(v);
      lim      = EXT_W'(1) << CB;
      eff_size = (ve > lim) ? SZ_W'(lim) : SZ_W'(ve);
   endfunction

   // control state
   logic [2:0]                   state_ff, state_in;
   logic [1:0]                   region_ff, region_in;
   logic                         done_ff, done_in;
   logic [1:0]                   slot_ff, slot_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [mer_pkg::CFG_BITS-1:0] width_ff, height_ff;
   logic                         fill_ff;

   // walk data
   logic signed [CW-1:0]           saved_cx_ff, saved_cx_in;
   logic signed [CW-1:0]           saved_cy_ff, saved_cy_in;
   logic [RB-1:0]                  saved_rx_ff, saved_rx_in;
   logic [RB-1:0]                  saved_ry_ff, saved_ry_in;
   logic [mer_pkg::COLOR_BITS-1:0] saved_color_ff, saved_color_in;
   logic [SQ_W-1:0]                sq_a_ff, sq_a_in;
   logic [SQ_W-1:0]                sq_b_ff, sq_b_in;
   logic [PROD_W-1:0]              prod_ff, prod_in;
   logic [OX_W-1:0]                off_x_ff, off_x_in;
   logic signed [OY_W-1:0]         off_y_ff, off_y_in;
   logic signed [DEC_W-1:0]        step_dx_ff, step_dx_in;
   logic signed [DEC_W-1:0]        step_dy_ff, step_dy_in;
   logic signed [DEC_W-1:0]        decision_ff, decision_in;
   logic signed [OFF_W-1:0]        p_ff, p_in;
   logic signed [OFF_W-1:0]        q_ff, q_in;
   mer_pkg::rsp_item_type          rsp_data_ff, rsp_data_in;

   // helpers
   logic [SZ_W-1:0]         w_eff, h_eff;
   logic [RB-1:0]           prime_a, prime_b;
   logic signed [DEC_W-1:0] sqa_d, sqb_d, prod_d;
   logic                    walk_ok;
   logic                    dec_le0;
   logic signed [OY_W-1:0]  off_y_nx;
   logic                    load;
   logic                    last_c;

   // result datapath
   logic signed [POS_W-1:0] cx_e, cy_e, p_e, q_e;
   logic signed [POS_W-1:0] x_plus, x_minus, y_plus, y_minus;
   logic signed [POS_W-1:0] w_s, h_s, wm1_s;
   logic signed [POS_W-1:0] pt_x, pt_y, row_y, l_s, r_s;
   logic                    pt_vis, sp_vis;
   mer_pkg::rsp_item_type   res_c;

   assign w_eff = eff_size(width_ff);
   assign h_eff = eff_size(height_ff);

   // region two walks the transposed ellipse
   assign prime_a = (region_ff == REGION_ONE) ? saved_rx_ff : saved_ry_ff;
   assign prime_b = (region_ff == REGION_ONE) ? saved_ry_ff : saved_rx_ff;

   assign sqa_d  = $signed(DEC_W'(sq_a_ff));
   assign sqb_d  = $signed(DEC_W'(sq_b_ff));
   assign prod_d = $signed(DEC_W'(prod_ff));

   assign walk_ok = (step_dx_ff < step_dy_ff) && (off_x_ff < w_eff) && !off_y_ff[OY_W-1];
   assign dec_le0 = decision_ff[DEC_W-1] || (decision_ff == '0);
   assign off_y_nx = dec_le0 ? off_y_ff : off_y_ff - OY_W'(1);

   assign load   = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign last_c = done_ff || (fill_ff ? (slot_ff == SLOT_SPAN_LAST)
                                       : (slot_ff == SLOT_POINT_LAST));

   // mirrored coordinates for the current slot
   always_comb begin
      cx_e    = POS_W'(saved_cx_ff);
      cy_e    = POS_W'(saved_cy_ff);
      p_e     = POS_W'(p_ff);
      q_e     = POS_W'(q_ff);
      x_plus  = cx_e + p_e;
      x_minus = cx_e - p_e;
      y_plus  = cy_e + q_e;
      y_minus = cy_e - q_e;
      w_s     = $signed(POS_W'(w_eff));
      h_s     = $signed(POS_W'(h_eff));
      wm1_s   = w_s - POS_W'(1);

      if (region_ff == REGION_ONE) begin
         pt_x = slot_ff[1] ? x_minus : x_plus;
         pt_y = slot_ff[0] ? y_minus : y_plus;
      end else begin
         pt_x = slot_ff[0] ? x_minus : x_plus;
         pt_y = slot_ff[1] ? y_minus : y_plus;
      end
      pt_vis = !pt_x[POS_W-1] && (pt_x < w_s) && !pt_y[POS_W-1] && (pt_y < h_s);

      row_y  = slot_ff[0] ? y_minus : y_plus;
      sp_vis = !row_y[POS_W-1] && (row_y < h_s)
               && !(x_minus[POS_W-1] && x_plus[POS_W-1])
               && !((x_minus >= w_s) && (x_plus >= w_s));
      l_s = x_minus[POS_W-1] ? '0 : ((x_minus > wm1_s) ? wm1_s : x_minus);
      r_s = x_plus[POS_W-1]  ? '0 : ((x_plus > wm1_s)  ? wm1_s : x_plus);

      res_c.pixel_color = saved_color_ff;
      res_c.last        = last_c;
      res_c.done_res    = 1'b0;
      if (done_ff) begin
         res_c.pixel_x     = '0;
         res_c.span_end_x  = '0;
         res_c.pixel_y     = '0;
         res_c.pixel_color = '0;
         res_c.visible     = 1'b0;
         res_c.done_res    = 1'b1;
      end else if (fill_ff) begin
         res_c.visible    = sp_vis;
         res_c.pixel_x    = sp_vis ? l_s[CB-1:0] : '0;
         res_c.span_end_x = sp_vis ? r_s[CB-1:0] : '0;
         res_c.pixel_y    = sp_vis ? row_y[CB-1:0] : '0;
      end else begin
         res_c.visible    = pt_vis;
         res_c.pixel_x    = pt_vis ? pt_x[CB-1:0] : '0;
         res_c.span_end_x = pt_vis ? pt_x[CB-1:0] : '0;
         res_c.pixel_y    = pt_vis ? pt_y[CB-1:0] : '0;
      end
   end

   always_comb begin
      state_in       = state_ff;
      region_in      = region_ff;
      done_in        = done_ff;
      slot_in        = slot_ff;
      saved_cx_in    = saved_cx_ff;
      saved_cy_in    = saved_cy_ff;
      saved_rx_in    = saved_rx_ff;
      saved_ry_in    = saved_ry_ff;
      saved_color_in = saved_color_ff;
      sq_a_in        = sq_a_ff;
      sq_b_in        = sq_b_ff;
      prod_in        = prod_ff;
      off_x_in       = off_x_ff;
      off_y_in       = off_y_ff;
      step_dx_in     = step_dx_ff;
      step_dy_in     = step_dy_ff;
      decision_in    = decision_ff;
      p_in           = p_ff;
      q_in           = q_ff;
      pop            = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               if (head.cmd.op == mer_pkg::CMD_LOAD) begin
                  saved_cx_in    = head.cmd.center_x;
                  saved_cy_in    = head.cmd.center_y;
                  saved_rx_in    = head.cmd.radius_x;
                  saved_ry_in    = head.cmd.radius_y;
                  saved_color_in = head.cmd.color;
                  region_in      = REGION_ONE;
                  state_in       = ST_PRIME_SQ;
               end else if (region_ff == REGION_DONE) begin
                  done_in  = 1'b1;
                  slot_in  = '0;
                  state_in = ST_EMIT;
               end else begin
                  done_in  = 1'b0;
                  state_in = ST_TEST;
               end
            end
         end
         ST_PRIME_SQ: begin
            sq_a_in    = SQ_W'(prime_a) * SQ_W'(prime_a);
            sq_b_in    = SQ_W'(prime_b) * SQ_W'(prime_b);
            off_x_in   = '0;
            off_y_in   = $signed(OY_W'(prime_b));
            step_dx_in = '0;
            state_in   = ST_PRIME_MUL;
         end
         ST_PRIME_MUL: begin
            prod_in  = PROD_W'(sq_a_ff) * PROD_W'(prime_b);
            state_in = ST_PRIME_SET;
         end
         ST_PRIME_SET: begin
            // scaled by 4: p = 4*b2 - 4*a2*b + a2, dy = 8*a2*b
            step_dy_in  = prod_d <<< 3;
            decision_in = (sqb_d <<< 2) - (prod_d <<< 2) + sqa_d;
            state_in    = (region_ff == REGION_ONE) ? ST_IDLE : ST_TEST;
         end
         ST_TEST: begin
            if (walk_ok) begin
               state_in = ST_UPDATE;
            end else if (region_ff == REGION_ONE) begin
               region_in = REGION_TWO;
               state_in  = ST_PRIME_SQ;
            end else begin
               region_in = REGION_DONE;
               done_in   = 1'b1;
               slot_in   = '0;
               state_in  = ST_EMIT;
            end
         end
         ST_UPDATE: begin
            if (dec_le0) begin
               decision_in = decision_ff + step_dx_ff + (sqb_d <<< 2);
            end else begin
               decision_in = decision_ff + step_dx_ff - step_dy_ff + (sqb_d <<< 2);
               step_dy_in  = step_dy_ff - (sqa_d <<< 3);
            end
            off_y_in   = off_y_nx;
            step_dx_in = step_dx_ff + (sqb_d <<< 3);
            off_x_in   = off_x_ff + OX_W'(1);
            // offsets as seen by this iteration: old x, new y
            if (region_ff == REGION_ONE) begin
               p_in = OFF_W'($signed({1'b0, off_x_ff}));
               q_in = OFF_W'(off_y_nx);
            end else begin
               p_in = OFF_W'(off_y_nx);
               q_in = OFF_W'($signed({1'b0, off_x_ff}));
            end
            slot_in  = '0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (load) begin
               slot_in = slot_ff + 2'd1;
               if (last_c) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load) begin
         rsp_data_in  = res_c;
         rsp_valid_in = 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         region_ff    <= REGION_DONE;
         done_ff      <= 1'b0;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         width_ff     <= mer_pkg::TARGET_WIDTH_RESET;
         height_ff    <= mer_pkg::TARGET_HEIGHT_RESET;
         fill_ff      <= mer_pkg::FILL_MODE_RESET;
      end else begin
         state_ff     <= state_in;
         region_ff    <= region_in;
         done_ff      <= done_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            unique case (csr_index)
               mer_pkg::CSR_TARGET_WIDTH:  width_ff  <= csr_wdata;
               mer_pkg::CSR_TARGET_HEIGHT: height_ff <= csr_wdata;
               mer_pkg::CSR_FILL_MODE:     fill_ff   <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      saved_cx_ff    <= saved_cx_in;
      saved_cy_ff    <= saved_cy_in;
      saved_rx_ff    <= saved_rx_in;
      saved_ry_ff    <= saved_ry_in;
      saved_color_ff <= saved_color_in;
      sq_a_ff        <= sq_a_in;
      sq_b_ff        <= sq_b_in;
      prod_ff        <= prod_in;
      off_x_ff       <= off_x_in;
      off_y_ff       <= off_y_in;
      step_dx_ff     <= step_dx_in;
      step_dy_ff     <= step_dy_in;
      decision_ff    <= decision_in;
      p_ff           <= p_in;
      q_ff           <= q_in;
      rsp_data_ff    <= rsp_data_in;
   end

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.done_res |-> rsp_data_ff.last && !rsp_data_ff.visible)
      else $error("done item without last or marked visible");

   a_result_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_EMIT)
      else $error("result item loaded outside the emit state");

   a_hidden_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.visible |->
         rsp_data_ff.pixel_x == '0 && rsp_data_ff.span_end_x == '0
         && rsp_data_ff.pixel_y == '0)
      else $error("hidden item carries coordinates");

   a_outline_point: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !fill_ff |-> rsp_data_ff.span_end_x == rsp_data_ff.pixel_x)
      else $error("outline item with a span end apart from its column");

endmodule

// File: hw/rtl/midpoint_ellipse_rasterizer_unit.sv
// top level of the midpoint ellipse rasterizer
//
//   port group  direction  handshake             carries
//   req_*       in         req_valid/req_stall   start or step item
//   rsp_*       out        rsp_valid/rsp_stall   point or span item
//   csr_*       in         csr_write_en          width, height, fill mode
//
// start item: dispatch, squaring, multiply and setup in the walk engine
// step item: dispatch, test and update, then 4 results in outline and 2 in fill mode;
//   a region change adds re-priming (squaring, multiply, setup); a step on the finished walk
//   goes from dispatch straight to emit and gives 1 result
// one walk engine and one result register serve all items, so items run in order
// a short queue keeps taking request items, until it is full, while the engine waits on rsp_stall
// reset is synchronous and leaves the walk finished with the reset area sizes
module midpoint_ellipse_rasterizer_unit #(
   parameter int QUEUE_DEPTH = mer_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  mer_pkg::req_item_type              req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output mer_pkg::rsp_item_type              rsp_data,
   input  logic                               csr_write_en,
   input  logic [mer_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [mer_pkg::CFG_BITS-1:0]       csr_wdata
);

   mer_pkg::queue_head_type head;
   logic                    pop;

   mer_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .head      (head),
      .pop       (pop)
   );

   mer_back u_back (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .head         (head),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

endmodule
